@@ design/ple_pkg.sv @@
// Shared definitions for the positional list engine.
// Holds operation and status codes, widths, and the cell command type.
// No dependencies.
package ple_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int OP_W         = 3;
   localparam int POS_W        = 5;
   localparam int STATUS_W     = 2;
   localparam int TOTAL_W      = 5;

   localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type            mode;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

@@ design/ple_cell.sv @@
// One storage cell of the list chain: holds a single element.
// Shifts from a neighbor, loads the new value or the head value, or holds, per broadcast command.
// Depends on ple_pkg.
module ple_cell #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  ple_pkg::cell_cmd_type             cmd,
   input  logic [IDX_W-1:0]                  sel_idx,
   input  logic [IDX_W-1:0]                  wrap_idx,
   input  logic signed [ple_pkg::DATA_W-1:0] left_data,
   input  logic signed [ple_pkg::DATA_W-1:0] right_data,
   input  logic signed [ple_pkg::DATA_W-1:0] head_data,
   output logic signed [ple_pkg::DATA_W-1:0] data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [ple_pkg::DATA_W-1:0] data_ff;
   logic signed [ple_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.mode)
         ple_pkg::CELL_HOLD: begin
            data_in = data_ff;
         end
         ple_pkg::CELL_INSERT: begin
            if (MY_IDX == sel_idx) begin
               data_in = cmd.value;
            end else if (MY_IDX > sel_idx) begin
               data_in = left_data;
            end
         end
         ple_pkg::CELL_DELETE: begin
            if (MY_IDX >= sel_idx) begin
               data_in = right_data;
            end
         end
         ple_pkg::CELL_ROTATE: begin
            if (MY_IDX == wrap_idx) begin
               data_in = head_data;
            end else begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ design/ple_chain.sv @@
// Row of list cells wired to their neighbors; exposes the head cell.
// Depends on ple_pkg and ple_cell.
module ple_chain #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  logic                              clock,
   input  ple_pkg::cell_cmd_type             cmd,
   input  logic [IDX_W-1:0]                  sel_idx,
   input  logic [IDX_W-1:0]                  wrap_idx,
   output logic signed [ple_pkg::DATA_W-1:0] head_data
);

   logic signed [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ple_pkg::DATA_W-1:0] left_w;
      logic signed [ple_pkg::DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end

      ple_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .sel_idx    (sel_idx),
         .wrap_idx   (wrap_idx),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

@@ design/positional_list_engine_core.sv @@
// Positional list engine: ordered list of signed words kept in a chain of cells.
// Edits take one transaction per cycle unless stalled, result the cycle after acceptance.
// A dump emits count results, one per cycle unless stalled, rotating chain through head.
// No new request is taken while a dump is in progress or a stalled result blocks.
// Synchronous active-high reset clears the count and control; cell contents are not reset.
// Depends on ple_pkg and ple_chain.
module positional_list_engine_core #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ple_pkg::OP_W-1:0]            req_op,
   input  logic signed [ple_pkg::DATA_W-1:0]   req_value,
   input  logic [ple_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ple_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ple_pkg::DATA_W-1:0]   rsp_element,
   output logic [ple_pkg::TOTAL_W-1:0]         rsp_entry_total,
   output logic                                rsp_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   dump_left_ff, dump_left_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [ple_pkg::DATA_W-1:0]  rsp_element_ff, rsp_element_in;
   logic [ple_pkg::TOTAL_W-1:0]        rsp_total_ff, rsp_total_in;
   logic                               rsp_last_ff, rsp_last_in;

   ple_pkg::cell_cmd_type              cmd;
   logic [IDX_W-1:0]                   sel_idx;
   logic [IDX_W-1:0]                   wrap_idx;
   logic signed [ple_pkg::DATA_W-1:0]  head_data;

   logic                               out_free;
   logic                               req_accept;
   logic                               load_rsp;
   logic                               is_full;
   logic                               is_empty;
   logic [CMP_W-1:0]                   pos_x;
   logic [CMP_W-1:0]                   cnt_x;
   logic [CMP_W-1:0]                   pos_m1;
   logic                               ins_pos_ok;
   logic                               del_pos_ok;

   ple_chain #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .sel_idx   (sel_idx),
      .wrap_idx  (wrap_idx),
      .head_data (head_data)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_stall  = !((state_ff == ST_IDLE) && out_free);
      req_accept = req_valid && !req_stall;

      is_full    = (count_ff == CNT_FULL);
      is_empty   = (count_ff == '0);
      pos_x      = CMP_W'(req_position);
      cnt_x      = CMP_W'(count_ff);
      pos_m1     = pos_x - CMP_W'(1);
      ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
      del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);

      cmd.mode     = ple_pkg::CELL_HOLD;
      cmd.value    = req_value;
      sel_idx      = '0;
      wrap_idx     = IDX_W'(count_ff - CNT_W'(1));

      state_in     = state_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      load_rsp     = 1'b0;
      rsp_status_in  = ple_pkg::STAT_OK;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;

      if (req_accept) begin
         load_rsp = 1'b1;
         unique case (req_op) inside
            ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST: begin
               if (is_full) begin
                  rsp_status_in = ple_pkg::STAT_FULL;
               end else begin
                  cmd.mode = ple_pkg::CELL_INSERT;
                  sel_idx  = (req_op == ple_pkg::OP_INS_FIRST) ? '0 : IDX_W'(count_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ple_pkg::OP_INS_AT: begin
               if (!ins_pos_ok) begin
                  rsp_status_in = ple_pkg::STAT_BADPOS;
               end else if (is_full) begin
                  rsp_status_in = ple_pkg::STAT_FULL;
               end else begin
                  cmd.mode = ple_pkg::CELL_INSERT;
                  sel_idx  = pos_m1[IDX_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST: begin
               if (is_empty) begin
                  rsp_status_in = ple_pkg::STAT_EMPTY;
               end else begin
                  cmd.mode = ple_pkg::CELL_DELETE;
                  sel_idx  = (req_op == ple_pkg::OP_DEL_FIRST) ? '0 : wrap_idx;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ple_pkg::OP_DEL_AT: begin
               if (is_empty) begin
                  rsp_status_in = ple_pkg::STAT_EMPTY;
               end else if (!del_pos_ok) begin
                  rsp_status_in = ple_pkg::STAT_BADPOS;
               end else begin
                  cmd.mode = ple_pkg::CELL_DELETE;
                  sel_idx  = pos_m1[IDX_W-1:0];
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ple_pkg::OP_DUMP: begin
               if (is_empty) begin
                  rsp_status_in = ple_pkg::STAT_EMPTY;
               end else begin
                  cmd.mode       = ple_pkg::CELL_ROTATE;
                  rsp_element_in = head_data;
                  rsp_last_in    = (count_ff == CNT_W'(1));
                  dump_left_in   = count_ff - CNT_W'(1);
                  if (count_ff != CNT_W'(1)) begin
                     state_in = ST_DUMP;
                  end
               end
            end
            default: begin
               rsp_status_in = ple_pkg::STAT_OK;
            end
         endcase
      end else if ((state_ff == ST_DUMP) && out_free) begin
         load_rsp       = 1'b1;
         cmd.mode       = ple_pkg::CELL_ROTATE;
         rsp_element_in = head_data;
         rsp_last_in    = (dump_left_ff == CNT_W'(1));
         dump_left_in   = dump_left_ff - CNT_W'(1);
         if (dump_left_ff == CNT_W'(1)) begin
            state_in = ST_IDLE;
         end
      end

      rsp_total_in = ple_pkg::TOTAL_W'(count_in);
      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_element_ff <= rsp_element_in;
         rsp_total_ff   <= rsp_total_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ design/ple_checker.sv @@
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg.
module ple_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [ple_pkg::OP_W-1:0]          req_op,
   input logic signed [ple_pkg::DATA_W-1:0] req_value,
   input logic [ple_pkg::POS_W-1:0]         req_position,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ple_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [ple_pkg::DATA_W-1:0] rsp_element,
   input logic [ple_pkg::TOTAL_W-1:0]       rsp_entry_total,
   input logic                              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_element)
         && $stable(rsp_entry_total) && $stable(rsp_last))
      else $error("stalled result changed");

   a_accept_responds: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_fail_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ple_pkg::STAT_OK) |-> (rsp_element == '0) && rsp_last)
      else $error("failed transaction result malformed");

   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ple_pkg::STAT_OK)
      else $error("non-final result with bad status");

   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken during dump");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (.*);

@@ dv/tb_top.sv @@
// Testbench for positional_list_engine_core: directed and random list edits and dumps.
// A queue mirror of the list predicts each result, which is checked field by field.
// Depends on ple_pkg and the positional_list_engine_core RTL.
module tb_top;

   localparam int LIST_CAP = ple_pkg::CAPACITY_DEF;
   localparam int MAX_WAIT = 14;
   localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
   localparam logic signed [ple_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [ple_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [ple_pkg::DATA_W-1:0] VAL_NEG1 = 32'shffff_ffff;

   typedef struct {
      logic [ple_pkg::STATUS_W-1:0]      status;
      logic signed [ple_pkg::DATA_W-1:0] element;
      logic [ple_pkg::TOTAL_W-1:0]       entry_total;
      logic                              last;
   } list_result_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [ple_pkg::OP_W-1:0]           req_op;
   logic signed [ple_pkg::DATA_W-1:0]  req_value;
   logic [ple_pkg::POS_W-1:0]          req_position;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [ple_pkg::STATUS_W-1:0]       rsp_status;
   logic signed [ple_pkg::DATA_W-1:0]  rsp_element;
   logic [ple_pkg::TOTAL_W-1:0]        rsp_entry_total;
   logic                               rsp_last;

   logic signed [ple_pkg::DATA_W-1:0]  list_mirror[$];
   list_result_type                    due_results[$];
   int                                 error_count;
   int                                 rsp_hold_left = 0;
   bit                                 no_idle;

   positional_list_engine_core #(
      .CAPACITY(LIST_CAP)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_entry_total (rsp_entry_total),
      .rsp_last        (rsp_last)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void queue_result(logic [ple_pkg::STATUS_W-1:0] status,
                                        logic signed [ple_pkg::DATA_W-1:0] element,
                                        logic last);
      list_result_type r;
      r.status      = status;
      r.element     = element;
      r.entry_total = ple_pkg::TOTAL_W'(list_mirror.size());
      r.last        = last;
      due_results.push_back(r);
   endfunction

   // Applies one accepted transaction to the mirror and queues its results.
   function automatic void apply_list_op(logic [ple_pkg::OP_W-1:0] op,
                                         logic signed [ple_pkg::DATA_W-1:0] value,
                                         logic [ple_pkg::POS_W-1:0] position);
      int                           n;
      int                           p;
      logic [ple_pkg::STATUS_W-1:0] st;
      n  = list_mirror.size();
      p  = int'(position);
      st = ple_pkg::STAT_OK;
      case (op) inside
         ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST, ple_pkg::OP_INS_AT: begin
            if (op == ple_pkg::OP_INS_AT && (p < 1 || p > n + 1))
               st = ple_pkg::STAT_BADPOS;
            else if (n >= LIST_CAP)
               st = ple_pkg::STAT_FULL;
            else if (op == ple_pkg::OP_INS_FIRST)
               list_mirror.push_front(value);
            else if (op == ple_pkg::OP_INS_LAST)
               list_mirror.push_back(value);
            else
               list_mirror.insert(p - 1, value);
         end
         ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST, ple_pkg::OP_DEL_AT: begin
            if (n == 0)
               st = ple_pkg::STAT_EMPTY;
            else if (op == ple_pkg::OP_DEL_AT && (p < 1 || p > n))
               st = ple_pkg::STAT_BADPOS;
            else if (op == ple_pkg::OP_DEL_FIRST)
               list_mirror.delete(0);
            else if (op == ple_pkg::OP_DEL_LAST)
               list_mirror.delete(n - 1);
            else
               list_mirror.delete(p - 1);
         end
         ple_pkg::OP_DUMP: begin
            if (n == 0) begin
               queue_result(ple_pkg::STAT_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  queue_result(ple_pkg::STAT_OK, list_mirror[i], i == n - 1);
            end
            return;
         end
         default: ;
      endcase
      queue_result(st, '0, 1'b1);
   endfunction

   task automatic issue_list_op(input logic [ple_pkg::OP_W-1:0] op,
                                input logic signed [ple_pkg::DATA_W-1:0] value,
                                input logic [ple_pkg::POS_W-1:0] position);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (gap) begin
         @(negedge clock);
         req_valid    <= 1'b0;
         req_op       <= ple_pkg::OP_W'($urandom);
         req_value    <= $urandom;
         req_position <= ple_pkg::POS_W'($urandom);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_value    <= value;
      req_position <= position;
      do
         @(posedge clock);
      while (req_stall);
      apply_list_op(op, value, position);
   endtask

   function automatic void check_field(string name,
                                       logic signed [ple_pkg::DATA_W-1:0] expected,
                                       logic signed [ple_pkg::DATA_W-1:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
         error_count++;
      end
   endfunction

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      list_result_type r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual status %0d element %0d",
                     $time, rsp_status, rsp_element);
            error_count++;
         end else begin
            r = due_results.pop_front();
            check_field("status", ple_pkg::DATA_W'(r.status), ple_pkg::DATA_W'(rsp_status));
            check_field("element", r.element, rsp_element);
            check_field("entry_total", ple_pkg::DATA_W'(r.entry_total),
                        ple_pkg::DATA_W'(rsp_entry_total));
            check_field("last", ple_pkg::DATA_W'(r.last), ple_pkg::DATA_W'(rsp_last));
         end
         rsp_hold_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
   end

   task automatic test_empty_list();
      issue_list_op(ple_pkg::OP_DUMP, $urandom, 5'd0);
      issue_list_op(ple_pkg::OP_DEL_FIRST, $urandom, 5'd1);
      issue_list_op(ple_pkg::OP_DEL_LAST, $urandom, 5'd1);
      issue_list_op(ple_pkg::OP_DEL_AT, $urandom, 5'd0);
      issue_list_op(OP_UNUSED, VAL_MAX, 5'd31);
   endtask

   task automatic test_insert_positions();
      issue_list_op(ple_pkg::OP_INS_FIRST, VAL_MAX, 5'd0);
      issue_list_op(ple_pkg::OP_INS_LAST, VAL_MIN, 5'd31);
      issue_list_op(ple_pkg::OP_INS_AT, VAL_NEG1, 5'd0);
      issue_list_op(ple_pkg::OP_INS_AT, VAL_NEG1, 5'd4);
      issue_list_op(ple_pkg::OP_INS_AT, VAL_NEG1, 5'd3);
      issue_list_op(ple_pkg::OP_INS_AT, '0, 5'd2);
   endtask

   task automatic test_full_list();
      no_idle = 1'b1;
      while (list_mirror.size() < LIST_CAP)
         issue_list_op(ple_pkg::OP_INS_LAST, $urandom, ple_pkg::POS_W'($urandom));
      no_idle = 1'b0;
      issue_list_op(ple_pkg::OP_INS_FIRST, $urandom, 5'd1);
      issue_list_op(ple_pkg::OP_INS_AT, $urandom, 5'd17);
      issue_list_op(ple_pkg::OP_INS_AT, $urandom, 5'd31);
      issue_list_op(ple_pkg::OP_INS_LAST, $urandom, 5'd1);
      issue_list_op(ple_pkg::OP_DUMP, $urandom, 5'd0);
   endtask

   task automatic test_delete_positions();
      issue_list_op(ple_pkg::OP_DEL_AT, $urandom, 5'd0);
      issue_list_op(ple_pkg::OP_DEL_AT, $urandom, 5'd17);
      issue_list_op(ple_pkg::OP_DEL_AT, $urandom, 5'd16);
      issue_list_op(ple_pkg::OP_DEL_FIRST, $urandom, 5'd0);
      issue_list_op(ple_pkg::OP_DEL_LAST, $urandom, 5'd0);
      issue_list_op(ple_pkg::OP_DEL_AT, $urandom, 5'd5);
      issue_list_op(ple_pkg::OP_DUMP, $urandom, 5'd0);
   endtask

   // Each phase of 40 items draws a random grow bias, so the list drifts between
   // empty and full; a fifth of the positions are arbitrary.
   task automatic test_random_traffic(input int n_items);
      int                                grow_pct;
      int                                n;
      int                                roll;
      logic [ple_pkg::OP_W-1:0]          op;
      logic [ple_pkg::POS_W-1:0]         position;
      logic signed [ple_pkg::DATA_W-1:0] value;
      for (int k = 0; k < n_items; k++) begin
         if (k % 40 == 0) begin
            grow_pct = $urandom_range(20, 80);
            no_idle  = ($urandom_range(0, 3) == 0);
         end
         n    = list_mirror.size();
         roll = $urandom_range(0, 99);
         if (roll < 4)
            op = OP_UNUSED;
         else if (roll < 14)
            op = ple_pkg::OP_DUMP;
         else if ($urandom_range(0, 99) < grow_pct)
            op = ple_pkg::OP_W'($urandom_range(ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_AT));
         else
            op = ple_pkg::OP_W'($urandom_range(ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_AT));
         if ($urandom_range(0, 4) == 0)
            position = ple_pkg::POS_W'($urandom_range(0, 31));
         else if (op == ple_pkg::OP_INS_AT)
            position = ple_pkg::POS_W'($urandom_range(1, n + 1));
         else
            position = (n == 0) ? '0 : ple_pkg::POS_W'($urandom_range(1, n));
         case ($urandom_range(0, 19))
            0: value = VAL_MAX;
            1: value = VAL_MIN;
            2: value = '0;
            3: value = VAL_NEG1;
            default: value = $urandom;
         endcase
         issue_list_op(op, value, position);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = '0;
      req_value     = '0;
      req_position  = '0;
      no_idle       = 1'b0;
      error_count   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_insert_positions();
      test_full_list();
      test_delete_positions();
      test_random_traffic(430);

      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
